>>> sv/min_heap_priority_queue_top_defines.svh
// Assertion macros shared by the min-heap priority queue RTL.
// Depends on nothing; every macro samples clk and is disabled while rst_n is low.
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication.
`define MHPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mhpq_pkg.sv
// Shared types and constants of the min-heap priority queue.
// Used by mhpq_ram, mhpq_ctrl and min_heap_priority_queue_top.
package mhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 11;
  localparam int STAT_W   = 2;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  // Memory access request from the controller.
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        ra_addr;
    logic [ADDR_W-1:0]        rb_addr;
  } ram_req_t;

endpackage

>>> sv/mhpq_ram.sv
// Heap storage: one write port and two read ports with registered read data.
// Depends on mhpq_pkg.
module mhpq_ram (
  input  logic                             clk,
  input  mhpq_pkg::ram_req_t               req,
  output logic signed [mhpq_pkg::DATA_W-1:0] ra_data,
  output logic signed [mhpq_pkg::DATA_W-1:0] rb_data
);
  import mhpq_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    ra_data <= mem[req.ra_addr];
    rb_data <= mem[req.rb_addr];
  end

endmodule

>>> sv/mhpq_ctrl.sv
// Heap sequencer: sift-up and sift-down over the storage, entry count, root cache
// and the result register. Depends on mhpq_pkg and the assertion macro header.
`include "min_heap_priority_queue_top_defines.svh"

module mhpq_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic signed [mhpq_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mhpq_pkg::DATA_W-1:0] out_extracted,
  output logic signed [mhpq_pkg::DATA_W-1:0] out_current_min,
  output logic [mhpq_pkg::CNT_W-1:0]         out_count,
  output logic                               out_is_empty,
  output logic [mhpq_pkg::STAT_W-1:0]        out_status,
  output mhpq_pkg::ram_req_t                 ram_req,
  input  logic signed [mhpq_pkg::DATA_W-1:0] ra_data,
  input  logic signed [mhpq_pkg::DATA_W-1:0] rb_data
);
  import mhpq_pkg::*;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [ADDR_W-1:0]        pos_r, pos_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] root_r, root_nxt;
  logic signed [DATA_W-1:0] ext_r, ext_nxt;
  status_t                  stat_r, stat_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_ext_r, out_ext_nxt;
  logic signed [DATA_W-1:0] out_min_r, out_min_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic                     out_emp_r, out_emp_nxt;
  status_t                  out_stat_r, out_stat_nxt;

  // Child indexes carry two extra bits so the right child of the last slot
  // does not wrap.
  logic [ADDR_W-1:0] parent;
  logic [ADDR_W+1:0] lc_w, rc_w, cnt_w;
  logic              rc_ok, take_l, take_r;
  logic signed [DATA_W-1:0] smaller;

  assign parent = (pos_r - 1'b1) >> 1;
  assign lc_w   = {1'b0, pos_r, 1'b1};
  assign rc_w   = lc_w + 1'b1;
  assign cnt_w  = {1'b0, count_r};
  assign rc_ok  = rc_w < cnt_w;
  assign take_l = ra_data < val_r;
  assign smaller = take_l ? ra_data : val_r;
  assign take_r = rc_ok && (rb_data < smaller);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    ext_nxt       = ext_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ext_nxt   = out_ext_r;
    out_min_nxt   = out_min_r;
    out_cnt_nxt   = out_cnt_r;
    out_emp_nxt   = out_emp_r;
    out_stat_nxt  = out_stat_r;
    ram_req       = '0;
    ram_req.ra_addr = pos_r;
    ram_req.rb_addr = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ext_nxt  = '0;
          stat_nxt = STAT_OK;
          if (in_kind == KIND_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              stat_nxt  = STAT_FULL;
              state_nxt = ST_DONE;
            end else begin
              count_nxt = count_r + 1'b1;
              pos_nxt   = count_r[ADDR_W-1:0];
              val_nxt   = in_value;
              state_nxt = ST_UP_CHK;
            end
          end else begin
            if (count_r == '0) begin
              stat_nxt  = STAT_EMPTY;
              state_nxt = ST_DONE;
            end else begin
              ext_nxt         = root_r;
              count_nxt       = count_r - 1'b1;
              ram_req.ra_addr = count_nxt[ADDR_W-1:0];
              state_nxt       = ST_DN_LAST;
            end
          end
        end
      end
      ST_UP_CHK: begin
        if (pos_r == '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = val_r;
          state_nxt     = ST_DONE;
        end else begin
          ram_req.ra_addr = parent;
          state_nxt       = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        if (val_r < ra_data) begin
          ram_req.wdata = ra_data;
          pos_nxt       = parent;
          state_nxt     = ST_UP_CHK;
        end else begin
          ram_req.wdata = val_r;
          state_nxt     = ST_DONE;
        end
      end
      ST_DN_LAST: begin
        val_nxt   = ra_data;
        pos_nxt   = '0;
        state_nxt = (count_r == '0) ? ST_DONE : ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (lc_w >= cnt_w) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = val_r;
          state_nxt     = ST_DONE;
        end else begin
          ram_req.ra_addr = lc_w[ADDR_W-1:0];
          ram_req.rb_addr = rc_w[ADDR_W-1:0];
          state_nxt       = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        if (take_r) begin
          ram_req.wdata = rb_data;
          pos_nxt       = rc_w[ADDR_W-1:0];
          state_nxt     = ST_DN_CHK;
        end else if (take_l) begin
          ram_req.wdata = ra_data;
          pos_nxt       = lc_w[ADDR_W-1:0];
          state_nxt     = ST_DN_CHK;
        end else begin
          ram_req.wdata = val_r;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ext_nxt   = ext_r;
          out_min_nxt   = (count_r == '0) ? '0 : root_r;
          out_cnt_nxt   = count_r;
          out_emp_nxt   = (count_r == '0);
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The root is mirrored in a register so every result can report it.
    root_nxt = root_r;
    if (ram_req.we && (ram_req.waddr == '0)) begin
      root_nxt = ram_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    root_r     <= root_nxt;
    ext_r      <= ext_nxt;
    stat_r     <= stat_nxt;
    out_ext_r  <= out_ext_nxt;
    out_min_r  <= out_min_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_emp_r  <= out_emp_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_extracted   = out_ext_r;
  assign out_current_min = out_min_r;
  assign out_count       = out_cnt_r;
  assign out_is_empty    = out_emp_r;
  assign out_status      = out_stat_r;

  `MHPQ_ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY),
    "entry count above capacity")
  `MHPQ_ASSERT_IMPLY(a_write_in_heap, ram_req.we, {1'b0, ram_req.waddr} < count_r,
    "heap write outside the occupied slots")
  `MHPQ_ASSERT_NEXT(a_extract_dec,
    in_valid && in_ready && (in_kind == KIND_EXTRACT) && (count_r != '0),
    count_r == $past(count_r) - 1'b1, "extract did not remove one entry")
  `MHPQ_ASSERT_IMPLY(a_full_status, out_valid_r && (out_stat_r == STAT_FULL),
    out_cnt_r == CNT_W'(CAPACITY), "full status reported below capacity")

endmodule

>>> sv/min_heap_priority_queue_top.sv
// Top level of the binary min-heap priority queue.
// Depends on mhpq_pkg, mhpq_ram and mhpq_ctrl.
//
//   Channel  Direction  Handshake              Request contents
//   in_      input      in_valid / in_ready    kind (0 insert, 1 extract), value
//   out_     output     out_valid / out_ready  extracted, current_min, count,
//                                              is_empty, status
//
// One request is worked at a time. An insert climbs toward the root and an extract
// descends toward a leaf; each level is one registered read of the heap memory
// followed by a compare-and-write.
// Reset clears the entry count, the sequencer state and the result valid; the memory
// keeps its contents and needs no clearing pass. A result that waits on out_ready
// holds the sequencer in its final state only if a second result is ready behind it;
// the next request is taken while the first result still waits.
module min_heap_priority_queue_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic signed [mhpq_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mhpq_pkg::DATA_W-1:0] out_extracted,
  output logic signed [mhpq_pkg::DATA_W-1:0] out_current_min,
  output logic [mhpq_pkg::CNT_W-1:0]         out_count,
  output logic                               out_is_empty,
  output logic [mhpq_pkg::STAT_W-1:0]        out_status
);
  import mhpq_pkg::*;

  // Memory request and the two registered read ports.
  ram_req_t                 ram_req;
  logic signed [DATA_W-1:0] ra_data;
  logic signed [DATA_W-1:0] rb_data;

  // The sequencer holds the count, the sifting value and the result register.
  mhpq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_extracted   (out_extracted),
    .out_current_min (out_current_min),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status),
    .ram_req         (ram_req),
    .ra_data         (ra_data),
    .rb_data         (rb_data)
  );

  // Heap array: one write and two reads per cycle, with registered read data.
  mhpq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the binary min-heap priority queue.
// Depends on mhpq_pkg and min_heap_priority_queue_top; a shadow heap inside
// the bench predicts every result and the result monitor compares it.
`timescale 1ns / 1ps

module testbench;
  import mhpq_pkg::*;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One predicted result, laid out like the out_ fields of the block.
  typedef struct {
    logic signed [DATA_W-1:0] extracted;
    logic signed [DATA_W-1:0] current_min;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    status_t                  status;
  } heap_outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_ready;
  logic                     in_kind;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_extracted;
  logic signed [DATA_W-1:0] out_current_min;
  logic [CNT_W-1:0]         out_count;
  logic                     out_is_empty;
  logic [STAT_W-1:0]        out_status;

  // Shadow copy of the heap. Only slots below heap_size are ever read.
  logic signed [DATA_W-1:0] heap_model [CAPACITY];
  int unsigned              heap_size;

  // Outcomes of accepted requests, oldest first.
  heap_outcome_t            outcome_queue [$];
  int                       error_count;

  // When set, both sides insert random idle bursts.
  bit                       idle_on;
  // A test writes a length here; the receiver copies it and holds off that long.
  int                       backpressure_len;

  min_heap_priority_queue_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_extracted  (out_extracted),
    .out_current_min(out_current_min),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow heap and returns the result the block
  // must report for it. Sift-up stops at an equal parent; sift-down moves only
  // to a strictly smaller child, and the left child is kept on a tie.
  function automatic heap_outcome_t apply_heap_op(logic kind, logic signed [DATA_W-1:0] value);
    heap_outcome_t            res;
    int unsigned              pos;
    int unsigned              parent;
    int unsigned              left;
    int unsigned              right;
    int unsigned              best;
    logic signed [DATA_W-1:0] tmp;
    res.extracted = '0;
    res.status    = STAT_OK;
    if (kind == KIND_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        heap_model[heap_size] = value;
        pos = heap_size;
        heap_size++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_model[pos] < heap_model[parent]) begin
            tmp                = heap_model[pos];
            heap_model[pos]    = heap_model[parent];
            heap_model[parent] = tmp;
            pos                = parent;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_size == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.extracted = heap_model[0];
        heap_model[0] = heap_model[heap_size-1];
        heap_size--;
        pos = 0;
        while (pos < heap_size) begin
          left  = 2 * pos + 1;
          right = 2 * pos + 2;
          best  = pos;
          if (left < heap_size && heap_model[left] < heap_model[best]) begin
            best = left;
          end
          if (right < heap_size && heap_model[right] < heap_model[best]) begin
            best = right;
          end
          if (best == pos) begin
            break;
          end
          tmp              = heap_model[pos];
          heap_model[pos]  = heap_model[best];
          heap_model[best] = tmp;
          pos              = best;
        end
      end
    end
    res.current_min = (heap_size > 0) ? heap_model[0] : '0;
    res.count       = heap_size[CNT_W-1:0];
    res.is_empty    = (heap_size == 0);
    return res;
  endfunction

  // Half full-range values, with a share of narrow values so that ties
  // between parents and children happen often, and the two extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      return $urandom;
    end else if (sel < 8) begin
      return $signed($urandom_range(0, 15)) - 8;
    end else if (sel == 8) begin
      return VAL_MIN;
    end else begin
      return VAL_MAX;
    end
  endfunction

  // Offers one request and returns at the falling edge after it is accepted.
  // Valid is left high so a request that follows at once needs no toggle; a
  // gap, or idle_sender, lowers it. Must be called at a falling edge.
  task automatic send_request(input logic kind, input logic signed [DATA_W-1:0] value);
    int gap_cycles;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap_cycles = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap_cycles) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_queue.push_back(apply_heap_op(kind, value));
    @(negedge clk);
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: random stall bursts while idle_on is set, and one long hold-off
  // whenever a test asks for it. The hold is counted here, cycle by cycle.
  initial begin : receiver
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (backpressure_len > 0) begin
        hold_left        = backpressure_len;
        backpressure_len = 0;
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        out_ready <= 1'b0;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result monitor: every accepted result is matched against the oldest
  // outstanding prediction, field by field.
  always @(posedge clk) begin
    heap_outcome_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_queue.size() == 0) begin
        $error("result with no request outstanding: extracted %0d count %0d status %0d",
               out_extracted, out_count, out_status);
        error_count++;
      end else begin
        exp_res = outcome_queue.pop_front();
        if (out_extracted !== exp_res.extracted) begin
          $error("out_extracted: expected %0d, actual %0d", exp_res.extracted, out_extracted);
          error_count++;
        end
        if (out_current_min !== exp_res.current_min) begin
          $error("out_current_min: expected %0d, actual %0d",
                 exp_res.current_min, out_current_min);
          error_count++;
        end
        if (out_count !== exp_res.count) begin
          $error("out_count: expected %0d, actual %0d", exp_res.count, out_count);
          error_count++;
        end
        if (out_is_empty !== exp_res.is_empty) begin
          $error("out_is_empty: expected %0d, actual %0d", exp_res.is_empty, out_is_empty);
          error_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("out_status: expected %0d, actual %0d", exp_res.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Hand-picked requests with no idling: an extract on an empty heap, the
  // value extremes, duplicates that make parents and children tie, then a
  // full drain that ends with another extract on an empty heap.
  task automatic test_directed();
    idle_on = 1'b0;
    send_request(KIND_EXTRACT, '0);
    send_request(KIND_INSERT, '0);
    send_request(KIND_INSERT, VAL_MAX);
    send_request(KIND_INSERT, VAL_MIN);
    send_request(KIND_INSERT, -1);
    send_request(KIND_INSERT, 5);
    send_request(KIND_INSERT, 5);
    send_request(KIND_INSERT, 3);
    send_request(KIND_INSERT, 3);
    send_request(KIND_INSERT, VAL_MIN);
    send_request(KIND_EXTRACT, VAL_MAX);
    repeat (9) send_request(KIND_EXTRACT, $urandom);
    send_request(KIND_EXTRACT, '0);
    send_request(KIND_INSERT, VAL_MAX);
    send_request(KIND_EXTRACT, '0);
    idle_sender();
  endtask

  // Even mix of inserts and extracts on a small heap, so that empty-heap
  // extracts keep turning up between short sifts.
  task automatic test_random_mix(input int n_requests);
    idle_on = 1'b1;
    repeat (n_requests) begin
      send_request(1'($urandom_range(0, 1)), pick_value());
    end
    idle_sender();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block has to stall its input until the results drain.
  task automatic test_backpressure(input int n_requests);
    idle_on          = 1'b0;
    backpressure_len = 400;
    repeat (n_requests) begin
      send_request(($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_EXTRACT, pick_value());
    end
    idle_sender();
  endtask

  // Grows the heap to capacity, refuses a few inserts at full, churns near
  // full, then drains it down to about 700 entries. Deep sift-ups and
  // sift-downs happen here. Idling stops for the tail of the drain.
  task automatic test_fill_and_drain();
    idle_on = 1'b1;
    while (heap_size < CAPACITY) begin
      send_request(($urandom_range(0, 15) == 0) ? KIND_EXTRACT : KIND_INSERT, pick_value());
    end
    repeat (3) send_request(KIND_INSERT, pick_value());
    repeat (40) send_request(1'($urandom_range(0, 1)), pick_value());
    while (heap_size > 700) begin
      if (heap_size < 850) begin
        idle_on = 1'b0;
      end
      send_request(($urandom_range(0, 15) == 0) ? KIND_INSERT : KIND_EXTRACT, pick_value());
    end
    repeat (2) send_request(KIND_EXTRACT, pick_value());
    idle_sender();
  endtask

  // Main sequence: one reset, the tests in turn, then the drain and verdict.
  initial begin : main_sequence
    int settle;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = KIND_INSERT;
    in_value         = '0;
    heap_size        = 0;
    error_count      = 0;
    idle_on          = 1'b0;
    backpressure_len = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_mix(100);
    test_backpressure(40);
    test_fill_and_drain();

    // Wait for every outstanding result, then keep watching so that a
    // stray result after the last one is still caught.
    settle = 0;
    while (outcome_queue.size() != 0 && settle < 100000) begin
      @(posedge clk);
      settle++;
    end
    repeat (40) @(posedge clk);

    if (error_count == 0 && outcome_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
